// ===== src/aise_pkg.sv =====
// ----------------------------------------------------------------------------
// AIS sentence encoder package
// Types, constants and character helpers shared by the encoder modules.
// ----------------------------------------------------------------------------
package aise_pkg;

  localparam int unsigned MSG_BITS      = 168;
  localparam int unsigned PAYLOAD_CHARS = 28;
  localparam int unsigned SENT_CHARS    = 47;
  localparam int unsigned IDX_W         = 6;

  localparam logic [5:0]  MSG_TYPE_A     = 6'd1;
  localparam logic [5:0]  MSG_TYPE_B     = 6'd18;
  localparam logic [26:0] CLASS_B_RADIO  = 27'd393222;

  localparam logic CMD_CLASS_A = 1'b0;
  localparam logic CMD_CLASS_B = 1'b1;

  localparam logic [1:0] CFG_TALKER_FIRST  = 2'd0;
  localparam logic [1:0] CFG_TALKER_SECOND = 2'd1;
  localparam logic [1:0] CFG_RADIO_CHANNEL = 2'd2;

  localparam logic [7:0] CHR_BANG  = 8'h21;
  localparam logic [7:0] CHR_COMMA = 8'h2C;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_STAR  = 8'h2A;
  localparam logic [7:0] CHR_ONE   = 8'h31;
  localparam logic [7:0] CHR_V     = 8'h56;
  localparam logic [7:0] CHR_D     = 8'h44;
  localparam logic [7:0] CHR_M     = 8'h4D;

  // Character positions within the sentence.
  localparam logic [IDX_W-1:0] IDX_TALKER1  = 6'd1;
  localparam logic [IDX_W-1:0] IDX_TALKER2  = 6'd2;
  localparam logic [IDX_W-1:0] IDX_MID      = 6'd3;
  localparam logic [IDX_W-1:0] IDX_CHANNEL  = 6'd12;
  localparam logic [IDX_W-1:0] IDX_COMMA1   = 6'd13;
  localparam logic [IDX_W-1:0] IDX_PAYLOAD  = 6'd14;
  localparam logic [IDX_W-1:0] IDX_COMMA2   = 6'd42;
  localparam logic [IDX_W-1:0] IDX_FILL     = 6'd43;
  localparam logic [IDX_W-1:0] IDX_STAR     = 6'd44;
  localparam logic [IDX_W-1:0] IDX_HEX_HI   = 6'd45;
  localparam logic [IDX_W-1:0] IDX_LAST     = 6'd46;

  // Fixed characters of the sentence that enter the checksum; the commas and
  // the two ones appear an even number of times and cancel.
  localparam logic [7:0] FIXED_SUM = CHR_V ^ CHR_D ^ CHR_M ^ CHR_ZERO;

  typedef struct packed {
    logic [7:0] talker_first;
    logic [7:0] talker_second;
    logic [7:0] radio_channel;
  } aise_cfg_t;

  typedef struct packed {
    logic [PAYLOAD_CHARS-1:0][7:0] chars;
    logic [7:0]                    psum;
  } aise_msg_t;

  function automatic logic [7:0] armor(input logic [5:0] v);
    logic [7:0] r;
    r = (v < 6'd40) ? (8'd48 + {2'b00, v}) : (8'd56 + {2'b00, v});
    return r;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    r = (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h37 + {4'h0, v});
    return r;
  endfunction

  // The text "VDM,1,1,," by position.
  function automatic logic [7:0] mid_char(input logic [3:0] i);
    logic [7:0] r;
    unique case (i)
      4'd0:    r = CHR_V;
      4'd1:    r = CHR_D;
      4'd2:    r = CHR_M;
      4'd4:    r = CHR_ONE;
      4'd6:    r = CHR_ONE;
      default: r = CHR_COMMA;
    endcase
    return r;
  endfunction

endpackage

// ===== src/aise_if.sv =====
// ----------------------------------------------------------------------------
// AIS sentence encoder channels
// Report input channel and sentence character output channel.
// ----------------------------------------------------------------------------
interface aise_report_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [29:0]        mmsi;
  logic [3:0]         nav_code;
  logic [9:0]         speed_tenths;
  logic signed [27:0] longitude;
  logic signed [26:0] latitude;
  logic [11:0]        course_tenths;
  logic [8:0]         heading_degrees;
  logic [5:0]         utc_second;

  modport source (
    output valid, command, mmsi, nav_code, speed_tenths, longitude, latitude,
           course_tenths, heading_degrees, utc_second,
    input  ready
  );
  modport sink (
    input  valid, command, mmsi, nav_code, speed_tenths, longitude, latitude,
           course_tenths, heading_degrees, utc_second,
    output ready
  );
endinterface

interface aise_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] sentence_char;
  logic       last_char;

  modport source (output valid, sentence_char, last_char, input ready);
  modport sink (input valid, sentence_char, last_char, output ready);
endinterface

// ===== src/aise_pack.sv =====
// ----------------------------------------------------------------------------
// AIS message packer
// Packs one report into the 168-bit message, armors it to 28 characters and
// registers them with their XOR.
// ----------------------------------------------------------------------------
module aise_pack (
  input  logic                clk_i,
  input  logic                rst_ni,
  aise_report_if.sink         report_i,
  output logic                msg_valid_o,
  output aise_pkg::aise_msg_t msg_o,
  input  logic                msg_take_i
);
  import aise_pkg::*;

  logic [MSG_BITS-1:0] bits;
  aise_msg_t           msg_d, msg_q;
  logic                valid_q;
  logic                accept;

  always_comb begin
    if (report_i.command == CMD_CLASS_B) begin
      bits = {MSG_TYPE_B, 2'b00, report_i.mmsi, 8'h00, report_i.speed_tenths, 1'b1,
              report_i.longitude, report_i.latitude, report_i.course_tenths,
              report_i.heading_degrees, report_i.utc_second, 2'b00, CLASS_B_RADIO};
    end else begin
      bits = {MSG_TYPE_A, 2'b00, report_i.mmsi, report_i.nav_code, 8'h00,
              report_i.speed_tenths, 1'b0, report_i.longitude, report_i.latitude,
              report_i.course_tenths, report_i.heading_degrees, report_i.utc_second,
              25'd0};
    end
  end

  always_comb begin
    msg_d.psum = '0;
    for (int k = 0; k < PAYLOAD_CHARS; k++) begin
      msg_d.chars[k] = armor(bits[MSG_BITS-1-6*k -: 6]);
      msg_d.psum     = msg_d.psum ^ msg_d.chars[k];
    end
  end

  assign report_i.ready = !valid_q || msg_take_i;
  assign accept         = report_i.valid && report_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (msg_take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      msg_q <= msg_d;
    end
  end

  assign msg_valid_o = valid_q;
  assign msg_o       = msg_q;

endmodule

// ===== src/aise_emit.sv =====
// ----------------------------------------------------------------------------
// AIS sentence emitter
// Holds one armored message and sends the 47 sentence characters in order,
// closing with the checksum.
// ----------------------------------------------------------------------------
module aise_emit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  aise_pkg::aise_cfg_t cfg_i,
  input  logic                msg_valid_i,
  input  aise_pkg::aise_msg_t msg_i,
  output logic                msg_take_o,
  aise_char_if.source         char_o
);
  import aise_pkg::*;

  logic             busy_q;
  logic [IDX_W-1:0] idx_q, idx_d;
  aise_msg_t        msg_q;
  logic             out_accept, last_done, take;
  logic [7:0]       sum;
  logic [IDX_W-1:0] poff, moff;
  logic [7:0]       chr;

  assign out_accept = busy_q && char_o.ready;
  assign last_done  = out_accept && (idx_q == IDX_LAST);
  assign take       = msg_valid_i && (!busy_q || last_done);
  assign msg_take_o = take;

  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = '0;
    end else if (out_accept) begin
      idx_d = idx_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      idx_q <= idx_d;
      if (take) begin
        busy_q <= 1'b1;
      end else if (last_done) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      msg_q <= msg_i;
    end
  end

  assign sum  = FIXED_SUM ^ cfg_i.talker_first ^ cfg_i.talker_second ^
                cfg_i.radio_channel ^ msg_q.psum;
  assign poff = idx_q - IDX_PAYLOAD;
  assign moff = idx_q - IDX_MID;

  always_comb begin
    priority if (idx_q < IDX_TALKER1) begin
      chr = CHR_BANG;
    end else if (idx_q == IDX_TALKER1) begin
      chr = cfg_i.talker_first;
    end else if (idx_q == IDX_TALKER2) begin
      chr = cfg_i.talker_second;
    end else if (idx_q < IDX_CHANNEL) begin
      chr = mid_char(moff[3:0]);
    end else if (idx_q == IDX_CHANNEL) begin
      chr = cfg_i.radio_channel;
    end else if (idx_q == IDX_COMMA1) begin
      chr = CHR_COMMA;
    end else if (idx_q < IDX_COMMA2) begin
      chr = msg_q.chars[poff[4:0]];
    end else if (idx_q == IDX_COMMA2) begin
      chr = CHR_COMMA;
    end else if (idx_q == IDX_FILL) begin
      chr = CHR_ZERO;
    end else if (idx_q == IDX_STAR) begin
      chr = CHR_STAR;
    end else if (idx_q == IDX_HEX_HI) begin
      chr = hex_digit(sum[7:4]);
    end else begin
      chr = hex_digit(sum[3:0]);
    end
  end

  assign char_o.valid         = busy_q;
  assign char_o.sentence_char = chr;
  assign char_o.last_char     = (idx_q == IDX_LAST);

endmodule

// ===== src/ais_position_report_sentence_encoder.sv =====
// ----------------------------------------------------------------------------
// AIS position report sentence encoder
// Turns one position report into the 47 characters of a !ttVDM sentence.
// ----------------------------------------------------------------------------
// Each report transaction yields exactly 47 character transactions on the
// output channel, one per cycle while the sink is ready, so the sustained rate
// is set by the output channel carrying one character per cycle. The first
// character is presented once the report has passed the packer's message
// register and then the emitter's message register, and the next report is
// accepted and packed while the previous sentence is still being sent. The
// talker and channel registers should be written only while no sentence is
// in flight.
// ----------------------------------------------------------------------------
module ais_position_report_sentence_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  aise_report_if.sink report_i,
  aise_char_if.source sentence_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import aise_pkg::*;

  aise_cfg_t cfg_q;
  aise_msg_t msg;
  logic      msg_valid;
  logic      msg_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.talker_first  <= 8'd65;
      cfg_q.talker_second <= 8'd73;
      cfg_q.radio_channel <= 8'd65;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_TALKER_FIRST) begin
        cfg_q.talker_first <= cfg_data_i;
      end
      if (cfg_index_i == CFG_TALKER_SECOND) begin
        cfg_q.talker_second <= cfg_data_i;
      end
      if (cfg_index_i == CFG_RADIO_CHANNEL) begin
        cfg_q.radio_channel <= cfg_data_i;
      end
    end
  end

  aise_pack u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .report_i    (report_i),
    .msg_valid_o (msg_valid),
    .msg_o       (msg),
    .msg_take_i  (msg_take)
  );

  aise_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .msg_valid_i (msg_valid),
    .msg_i       (msg),
    .msg_take_o  (msg_take),
    .char_o      (sentence_o)
  );

endmodule
